// ===== hw/rtl/fir_conv_pkg.sv =====
// Shared types and constants for the streaming FIR convolver.
`timescale 1ns / 1ps
`default_nettype none

package fir_conv_pkg;

    localparam int MAX_TAPS_DEF = 16;   // default tap table depth
    localparam int COEF_W       = 16;   // signed Q1.15 coefficient
    localparam int SAMPLE_W     = 16;   // signed sample
    localparam int IDX_W        = 4;    // coef_index field width
    localparam int PROD_W       = COEF_W + SAMPLE_W;
    localparam int ACC_W        = 36;   // filtered field width
    localparam int TAPS_W       = 5;    // taps_in_use register width
    localparam int TAPS_RESET   = 11;
    localparam int IN_TDATA_W   = 40;   // coef_index, coef_value, sample, pad
    localparam int OUT_TDATA_W  = 40;   // filtered, pad
    localparam int IN_TUSER_W   = 2;    // cmd, start_of_block

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_FILTER = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/fir_convolver.sv =====
// Top level of the streaming FIR convolver with a loadable tap table.
// Usage:
//   Input items arrive on the s-side stream. tuser[0] is the command: a load
//   item writes coef_value into the tap table at coef_index and gives no result;
//   a filter item gives one 36-bit full-precision sum on the m-side stream.
//   tuser[1] on a filter item clears the sample history first.
//   taps_in_use is written by the user via i_cfg_we / i_cfg_wdata only while
//   idle (not enforced by the block); zero is one tap, above MAX_TAPS is MAX_TAPS.
// Sequencing:
//   A load item is written into the tap table while the block stays idle. A
//   filter item runs on one shared multiply-accumulate that walks the taps,
//   one coefficient and one history word read per cycle from the two memories,
//   then a product stage, an accumulate and the write-back.
//   The next item is taken in the cycle after the result is registered.
// Reset:
//   Clears the tap table (per-entry valid bits), empties the history through
//   its fill count, loads taps_in_use with 11 and drops any pending result.
// Backpressure:
//   While the receiver stalls the result register holds its item; the next
//   filter item waits before its write-back until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module fir_convolver
    import fir_conv_pkg::*;
#(
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration: taps_in_use
    input  wire logic                    i_cfg_we,
    input  wire logic [TAPS_W-1:0]       i_cfg_wdata,
    // input items
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // [3:0] coef_index, [19:4] coef_value, [35:20] sample, [39:36] zero
    input  wire logic [IN_TDATA_W-1:0]   s_tdata,
    // [0] cmd, [1] start_of_block
    input  wire logic [IN_TUSER_W-1:0]   s_tuser,
    // result items
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // [35:0] filtered, [39:36] zero
    output logic [OUT_TDATA_W-1:0]       m_tdata
);

    localparam int HIST_D = MAX_TAPS - 1;
    localparam int KW     = $clog2(MAX_TAPS);
    localparam int NW     = $clog2(MAX_TAPS + 1);
    localparam int HP     = (HIST_D > 1) ? $clog2(HIST_D) : 1;
    localparam int PAD_W  = OUT_TDATA_W - ACC_W;

    // input field unpacking
    logic [IDX_W-1:0]           in_idx;
    logic signed [COEF_W-1:0]   in_coef;
    logic signed [SAMPLE_W-1:0] in_sample;
    t_cmd                       in_cmd;
    logic                       in_sob;

    assign in_idx    = s_tdata[IDX_W-1:0];
    assign in_coef   = s_tdata[IDX_W +: COEF_W];
    assign in_sample = s_tdata[IDX_W+COEF_W +: SAMPLE_W];
    assign in_cmd    = t_cmd'(s_tuser[0]);
    assign in_sob    = s_tuser[1];

    // memories
    logic [COEF_W-1:0]   coef_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0] r_coef_vld;
    logic [SAMPLE_W-1:0] hist_mem [HIST_D];

    // control state
    t_state              r_state, n_state;
    logic [TAPS_W-1:0]   r_taps;
    logic [NW-1:0]       r_n;
    logic [KW-1:0]       r_k;
    logic [KW-1:0]       r_fill;
    logic [HP-1:0]       r_rp;
    logic [HP-1:0]       r_wp;
    logic signed [SAMPLE_W-1:0] r_x;

    // datapath pipeline
    logic                       r_p1_vld, r_p1_hist, r_p1_cur;
    logic signed [COEF_W-1:0]   r_coef_q;
    logic                       r_cvld_q;
    logic signed [SAMPLE_W-1:0] r_hist_q;
    logic                       r_p2_vld;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;

    // result register
    logic                r_out_vld;
    logic [ACC_W-1:0]    r_out_data;

    // control decode
    logic          accept, load_go, filter_go, issue, last_issue, out_free, finish;
    logic [NW-1:0] eff_taps;

    assign accept    = s_tvalid && s_tready;
    assign load_go   = accept && (in_cmd == CMD_LOAD);
    assign filter_go = accept && (in_cmd == CMD_FILTER);
    assign out_free  = !r_out_vld || m_tready;
    assign last_issue = (r_k == KW'(r_n - NW'(1)));

    // clamp the tap count to 1..MAX_TAPS
    always_comb begin
        if (r_taps == '0) begin
            eff_taps = NW'(1);
        end else if (32'(r_taps) > MAX_TAPS) begin
            eff_taps = NW'(MAX_TAPS);
        end else begin
            eff_taps = NW'(r_taps);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (filter_go) n_state = ST_RUN;
            ST_RUN:   if (last_issue) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_p1_vld && !r_p2_vld && out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready = 1'b0;
        issue    = 1'b0;
        finish   = 1'b0;
        unique case (r_state)
            ST_IDLE:  s_tready = 1'b1;
            ST_RUN:   issue    = 1'b1;
            ST_DRAIN: finish   = !r_p1_vld && !r_p2_vld && out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taps <= TAPS_W'(TAPS_RESET);
        end else if (i_cfg_we) begin
            r_taps <= i_cfg_wdata;
        end
    end

    // tap table: loads beyond the table are dropped
    always_ff @(posedge i_clk) begin
        if (load_go && (32'(in_idx) < MAX_TAPS)) begin
            coef_mem[KW'(in_idx)] <= in_coef;
        end
        if (issue) begin
            r_coef_q <= coef_mem[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_vld <= '0;
        end else if (load_go && (32'(in_idx) < MAX_TAPS)) begin
            r_coef_vld[KW'(in_idx)] <= 1'b1;
        end
    end

    // history ring: write the current sample back once its sum is done
    always_ff @(posedge i_clk) begin
        if (finish) begin
            hist_mem[r_wp] <= r_x;
        end
        if (issue) begin
            r_hist_q <= hist_mem[r_rp];
        end
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else begin
            if (filter_go && in_sob) begin
                r_fill <= '0;
            end else if (finish && (r_fill != KW'(HIST_D))) begin
                r_fill <= r_fill + KW'(1);
            end
            if (finish) begin
                r_wp <= (r_wp == HP'(HIST_D - 1)) ? '0 : r_wp + HP'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (filter_go) begin
            r_x  <= in_sample;
            r_n  <= eff_taps;
            r_k  <= '0;
            // start at the write pointer: tap zero uses the current sample, so
            // the previous sample is read on the step after it
            r_rp <= r_wp;
        end else if (issue) begin
            r_k  <= r_k + KW'(1);
            r_rp <= (r_rp == '0) ? HP'(HIST_D - 1) : r_rp - HP'(1);
        end
    end

    // read stage tags and coefficient valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
        end else begin
            r_p1_vld <= issue;
            r_p2_vld <= r_p1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_cvld_q  <= r_coef_vld[r_k];
            r_p1_cur  <= (r_k == '0);
            // history entry k-1 exists only if that many samples came in
            r_p1_hist <= (r_k != '0) && ((r_k - KW'(1)) < r_fill);
        end
    end

    // multiply stage
    logic signed [COEF_W-1:0]   mul_a;
    logic signed [SAMPLE_W-1:0] mul_b;

    always_comb begin
        mul_a = r_cvld_q ? r_coef_q : '0;
        if (r_p1_hist) begin
            mul_b = r_hist_q;
        end else if (r_p1_cur) begin
            mul_b = r_x;
        end else begin
            mul_b = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1_vld) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // accumulate, wrapping at the result width
    always_ff @(posedge i_clk) begin
        if (filter_go) begin
            r_acc <= '0;
        end else if (r_p2_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (finish) begin
            r_out_vld <= 1'b1;
        end else if (m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_data <= r_acc;
        end
    end

    assign m_tvalid = r_out_vld;
    assign m_tdata  = {{PAD_W{1'b0}}, r_out_data};

endmodule

`default_nettype wire
